@@ rtl/dqmt_pkg.sv @@
// Shared types, constants and the quadrature step table for the dual-axis move controller.
`timescale 1ns / 1ps
package dqmt_pkg;

   localparam int POS_BITS = 32;
   localparam int OUT_POS_W = 32;
   localparam int MOVE_W = 24;
   localparam int MM_W = MOVE_W + 1;
   localparam int K_W = 24;
   localparam int SPEED_W = 8;
   localparam int FRAC_W = 24;
   localparam int MAG_W = MM_W + K_W - FRAC_W;
   localparam int EXT_W = (POS_BITS > MAG_W + 1) ? POS_BITS : MAG_W + 1;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = K_W;

   localparam logic [K_W-1:0] K_RESET = K_W'(10764150);
   localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(150);

   localparam logic [EXT_W-1:0] LIM_POS = EXT_W'((65'd1 << (POS_BITS - 1)) - 65'd1);
   localparam logic [EXT_W-1:0] LIM_NEG = EXT_W'(65'd1 << (POS_BITS - 1));

   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_PER_MM = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_SPEED = 1'd1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_MOVE = 1'b1;

   typedef logic signed [POS_BITS-1:0] pos_type;
   typedef logic signed [MM_W-1:0] mm_type;
   typedef logic [K_W-1:0] k_type;
   typedef logic [SPEED_W-1:0] speed_type;
   typedef logic [MAG_W-1:0] mag_type;
   typedef logic signed [1:0] step_type;

   localparam step_type ST_HOLD = 2'sb00;
   localparam step_type ST_UP = 2'sb01;
   localparam step_type ST_DOWN = 2'sb11;

   // index is {previous pins, current pins}
   localparam step_type STEP_LUT [16] = '{
      ST_HOLD, ST_DOWN, ST_UP,   ST_HOLD,
      ST_UP,   ST_HOLD, ST_HOLD, ST_DOWN,
      ST_DOWN, ST_HOLD, ST_HOLD, ST_UP,
      ST_HOLD, ST_UP,   ST_DOWN, ST_HOLD
   };

   typedef struct packed {
      logic opcode;
      logic [1:0] pins_a;
      logic [1:0] pins_b;
      logic signed [MOVE_W-1:0] move_dx;
      logic signed [MOVE_W-1:0] move_dy;
   } req_type;

   typedef struct packed {
      logic signed [OUT_POS_W-1:0] position_a;
      logic signed [OUT_POS_W-1:0] position_b;
      logic [SPEED_W-1:0] drive_a;
      logic [SPEED_W-1:0] drive_b;
      logic forward_a;
      logic forward_b;
      logic busy_res;
   } rsp_type;

   typedef struct packed {
      logic ld1;
      logic ld2;
      logic commit;
   } pipe_ctrl_type;

   typedef struct packed {
      logic signed [POS_BITS-1:0] count;
      logic run;
      logic fwd;
   } lane_out_type;

endpackage

@@ rtl/dqmt_lane.sv @@
// One motor axis: abs and scale pipeline, quadrature decode, target tracking.
`timescale 1ns / 1ps
module dqmt_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  dqmt_pkg::pipe_ctrl_type ctrl,
   input  logic                    opcode,
   input  logic [1:0]              pins,
   input  dqmt_pkg::mm_type        mm,
   input  dqmt_pkg::k_type         k,
   output dqmt_pkg::lane_out_type  nxt
);
   import dqmt_pkg::*;

   logic op1_ff;
   logic [1:0] pins1_ff;
   mm_type mm1_ff;

   logic op2_ff;
   logic [1:0] pins2_ff;
   logic neg2_ff;
   mag_type mag2_ff;

   logic [1:0] last_ff, last_in;
   pos_type count_ff, count_in;
   pos_type target_ff, target_in;
   logic run_ff, run_in;
   logic fwd_ff, fwd_in;

   logic [MM_W-1:0] amm;
   logic [MM_W+K_W-1:0] prod;
   logic [EXT_W-1:0] mag_ext;
   logic [POS_BITS-1:0] mag_p;
   pos_type cnt_step;
   logic reached;

   always_comb begin
      amm = mm1_ff[MM_W-1] ? MM_W'(-mm1_ff) : MM_W'(mm1_ff);
      prod = (MM_W+K_W)'(amm) * (MM_W+K_W)'(k);
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld1) begin
         op1_ff <= opcode;
         pins1_ff <= pins;
         mm1_ff <= mm;
      end
      if (ctrl.ld2) begin
         op2_ff <= op1_ff;
         pins2_ff <= pins1_ff;
         neg2_ff <= mm1_ff[MM_W-1];
         mag2_ff <= prod[FRAC_W +: MAG_W];
      end
   end

   always_comb begin
      last_in = last_ff;
      count_in = count_ff;
      target_in = target_ff;
      run_in = run_ff;
      fwd_in = fwd_ff;
      cnt_step = count_ff + pos_type'(STEP_LUT[{last_ff, pins2_ff}]);
      reached = fwd_ff ? (target_ff <= cnt_step) : (cnt_step <= target_ff);
      mag_ext = EXT_W'(mag2_ff);
      if (!neg2_ff && mag_ext > LIM_POS) begin
         mag_ext = LIM_POS;
      end
      if (neg2_ff && mag_ext > LIM_NEG) begin
         mag_ext = LIM_NEG;
      end
      mag_p = mag_ext[POS_BITS-1:0];
      if (ctrl.commit) begin
         if (op2_ff == OP_MOVE) begin
            // two's complement negate folded into the adder carry-in
            target_in = count_ff + pos_type'(mag_p ^ {POS_BITS{neg2_ff}})
                        + pos_type'(neg2_ff);
            run_in = mag2_ff != '0;
            fwd_in = !neg2_ff || (mag2_ff == '0);
         end else begin
            last_in = pins2_ff;
            count_in = cnt_step;
            if (run_ff && reached) begin
               run_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         count_ff <= '0;
         target_ff <= '0;
         run_ff <= 1'b0;
         fwd_ff <= 1'b1;
      end else begin
         last_ff <= last_in;
         count_ff <= count_in;
         target_ff <= target_in;
         run_ff <= run_in;
         fwd_ff <= fwd_in;
      end
   end

   assign nxt = '{count: count_in, run: run_in, fwd: fwd_in};

endmodule

@@ rtl/dqmt_merge.sv @@
// Merges both axes into the result register and holds it until transferred.
`timescale 1ns / 1ps
module dqmt_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   commit,
   input  dqmt_pkg::lane_out_type nxt_a,
   input  dqmt_pkg::lane_out_type nxt_b,
   input  dqmt_pkg::speed_type    speed,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output dqmt_pkg::rsp_type      rsp_data
);
   import dqmt_pkg::*;

   logic valid_ff, valid_in;
   rsp_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (commit) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         data_ff.position_a <= OUT_POS_W'(nxt_a.count);
         data_ff.position_b <= OUT_POS_W'(nxt_b.count);
         data_ff.drive_a <= nxt_a.run ? speed : '0;
         data_ff.drive_b <= nxt_b.run ? speed : '0;
         data_ff.forward_a <= nxt_a.fwd;
         data_ff.forward_b <= nxt_b.fwd;
         data_ff.busy_res <= nxt_a.run || nxt_b.run;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

@@ rtl/dual_quadrature_move_to_target.sv @@
// Top level of the two-motor quadrature position and move-to-target controller.
//
// Items arrive on req_ (valid/stall): an encoder pin sample for both motors or a
// move command in mm. Every item gives one result on rsp_ (valid/stall) with both
// counts, drive levels, directions and the busy flag after that item.
// csr_ writes counts_per_mm, unsigned Q0.24 (index 0), and drive_speed (index 1);
// csr_ready is always high. Writes must be made only while no item is in flight;
// the block does not enforce this. One item is taken every cycle unless req_stall
// is high: two pipeline stages (scale multiply per lane, then the state update
// that every item depends on) are followed by the result register. When the
// receiver stalls, the result register holds and the stages behind it keep
// filling; req_stall rises once both stages and the result are full.
// Synchronous reset clears counts, targets and pin history, stops both motors,
// sets forward direction and restores the register defaults.
`timescale 1ns / 1ps
module dual_quadrature_move_to_target (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dqmt_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dqmt_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dqmt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dqmt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dqmt_pkg::*;

   k_type k_ff, k_in;
   speed_type speed_ff, speed_in;
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic rdy_out, adv2, commit, accept;
   pipe_ctrl_type ctrl;
   mm_type mm_a, mm_b;
   lane_out_type nxt_a, nxt_b;

   assign csr_ready = 1'b1;

   always_comb begin
      k_in = k_ff;
      speed_in = speed_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COUNTS_PER_MM: k_in = csr_wdata[K_W-1:0];
            CSR_DRIVE_SPEED:   speed_in = csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rdy_out = !rsp_valid || !rsp_stall;
      commit = v2_ff && rdy_out;
      adv2 = v1_ff && (!v2_ff || rdy_out);
      req_stall = v1_ff && !(!v2_ff || rdy_out);
      accept = req_valid && !req_stall;
      v1_in = accept ? 1'b1 : (adv2 ? 1'b0 : v1_ff);
      v2_in = adv2 ? 1'b1 : (commit ? 1'b0 : v2_ff);
      ctrl = '{ld1: accept, ld2: adv2, commit: commit};
      mm_a = mm_type'(req_data.move_dx) - mm_type'(req_data.move_dy);
      mm_b = mm_type'(req_data.move_dx) + mm_type'(req_data.move_dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= K_RESET;
         speed_ff <= SPEED_RESET;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         speed_ff <= speed_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   dqmt_lane u_lane_a (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .opcode (req_data.opcode),
      .pins   (req_data.pins_a),
      .mm     (mm_a),
      .k      (k_ff),
      .nxt    (nxt_a)
   );

   dqmt_lane u_lane_b (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .opcode (req_data.opcode),
      .pins   (req_data.pins_b),
      .mm     (mm_b),
      .k      (k_ff),
      .nxt    (nxt_b)
   );

   dqmt_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .commit    (commit),
      .nxt_a     (nxt_a),
      .nxt_b     (nxt_b),
      .speed     (speed_ff),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid && (rsp_data.busy_res == ($past(nxt_a.run) || $past(nxt_b.run))))
      else $error("committed item not presented");

   a_idle_no_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> rsp_data.drive_a == '0 && rsp_data.drive_b == '0)
      else $error("drive active while not busy");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && v2_ff)
      else $error("input stalled without output back-pressure");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !v1_ff && !v2_ff)
      else $error("pipeline not empty after reset");

endmodule
